// ----- rtl/core/log_recovery_deframer_macros.svh -----
// Assertion macros for the log recovery deframer.
// Included by lrd_queue, which carries the concurrent checks; no other dependencies.
`ifndef LOG_RECOVERY_DEFRAMER_MACROS_SVH
`define LOG_RECOVERY_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LRD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lrd check failed");

// Next-cycle implication, disabled during reset.
`define LRD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lrd check failed");

`endif

// ----- rtl/core/lrd_pkg.sv -----
// Shared types, codes and the CRC-32 table function for the log recovery deframer.
// No dependencies; the front, queue, back, top level and testbench import it.
package lrd_pkg;

   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam logic [31:0] MAX_FRAME_RESET = 32'd10485760;
   localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;
   localparam logic [33:0] HDR_BYTES    = 34'd25;

   // parser phases
   localparam logic [1:0] PH_SIZE = 2'd0;
   localparam logic [1:0] PH_BODY = 2'd1;
   localparam logic [1:0] PH_STOP = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_KEY       = 3'd0;
   localparam logic [2:0] KIND_VALUE     = 3'd1;
   localparam logic [2:0] KIND_ACCEPTED  = 3'd2;
   localparam logic [2:0] KIND_CRC_BAD   = 3'd3;
   localparam logic [2:0] KIND_MALFORMED = 3'd4;
   localparam logic [2:0] KIND_LOG_END   = 3'd5;
   localparam logic [2:0] KIND_STOPPED   = 3'd6;

   // what one log byte leaves for the back end: up to two results
   typedef struct packed {
      logic        a_vld;
      logic [2:0]  a_kind;
      logic [7:0]  a_pay;
      logic        b_vld;
      logic [2:0]  b_kind;
      logic [7:0]  rec_type;
      logic [63:0] rec_seq;
      logic [63:0] rec_ts;
      logic [31:0] rec_klen;
      logic [31:0] rec_vlen;
      logic [63:0] highest;
   } lrd_event_type;

   function automatic logic [31:0] crc_entry(input logic [7:0] idx);
      logic [31:0] c;
      c = {24'd0, idx};
      for (int j = 0; j < 8; j++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

endpackage

// ----- rtl/core/lrd_req_if.sv -----
// Log byte channel: valid/ready with the raw byte and end-of-log mark.
// No dependencies.
interface lrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] log_byte;
   logic       final_req;
   modport source(output valid, log_byte, final_req, input ready);
   modport sink(input valid, log_byte, final_req, output ready);
endinterface

// ----- rtl/core/lrd_rsp_if.sv -----
// Result channel: valid/ready with the result record fields.
// No dependencies.
interface lrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  payload_byte;
   logic [7:0]  record_type;
   logic [63:0] sequence_number;
   logic [63:0] time_stamp;
   logic [31:0] key_length;
   logic [31:0] value_length;
   logic [63:0] highest_sequence;
   logic        last;
   modport source(output valid, kind, payload_byte, record_type, sequence_number,
                  time_stamp, key_length, value_length, highest_sequence, last,
                  input ready);
   modport sink(input valid, kind, payload_byte, record_type, sequence_number,
                time_stamp, key_length, value_length, highest_sequence, last,
                output ready);
endinterface

// ----- rtl/core/log_recovery_deframer.sv -----
// Write-ahead log deframer: length-prefixed frames with CRC-32, key/value streaming.
// A byte's results pass through the event queue and then the result register.
// One log byte per cycle while the event queue has room; a byte that causes two
// results leaves two transfers in the single result register; the queue absorbs it.
// Reset (synchronous, active high): parser back to reading a size field, frame
// limit to 10 MiB, sequence maximum to zero, queue and result register empty.
// Depends on lrd_pkg, lrd_req_if, lrd_rsp_if, lrd_front, lrd_queue, lrd_back.
module log_recovery_deframer #(
   parameter int unsigned QUEUE_DEPTH = lrd_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   lrd_req_if.sink     req_bus,
   lrd_rsp_if.source   rsp_bus
);
   import lrd_pkg::*;

   lrd_event_type ev, head;
   logic          ev_vld, take, full, empty, pop;

   // Take a byte whenever the queue has room for the event it may leave.
   assign req_bus.ready = !full;
   assign take          = req_bus.valid && req_bus.ready;

   // Front: parse the byte, update frame state, classify what it produces.
   lrd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .take_i    (take),
      .byte_i    (req_bus.log_byte),
      .final_i   (req_bus.final_req),
      .ev_vld_o  (ev_vld),
      .ev_o      (ev)
   );

   // Queue: decouple parsing from result delivery; push only bytes with results.
   lrd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_i      (ev_vld),
      .push_data_i (ev),
      .pop_i       (pop),
      .full_o      (full),
      .empty_o     (empty),
      .head_o      (head)
   );

   // Back: drain events, one result per transfer on the output side.
   lrd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .empty_i (empty),
      .head_i  (head),
      .pop_o   (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// ----- rtl/core/lrd_front.sv -----
// Front end: parses one log byte per transfer, keeps frame/CRC/header state
// and produces an event for each byte that leaves a result. Depends on lrd_pkg.
module lrd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [31:0]            csr_wdata,
   input  logic                   take_i,
   input  logic [7:0]             byte_i,
   input  logic                   final_i,
   output logic                   ev_vld_o,
   output lrd_pkg::lrd_event_type ev_o
);
   import lrd_pkg::*;

   logic [31:0] max_ff, max_in;
   logic [1:0]  phase_ff, phase_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] scs_ff, scs_in;
   logic [7:0]  type_ff, type_in;
   logic [63:0] seq_ff, seq_in;
   logic [63:0] ts_ff, ts_in;
   logic [31:0] kc_ff, kc_in;
   logic [31:0] vc_ff, vc_in;
   logic        mal_ff, mal_in;
   logic [63:0] hi_ff, hi_in;

   logic [33:0] p34, d34, kb, off;
   logic [31:0] pos_inc;
   logic [2:0]  bsel;
   logic        trunc;

   always_comb begin
      max_in   = csr_we ? csr_wdata : max_ff;
      phase_in = phase_ff;
      size_in  = size_ff;
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      scs_in   = scs_ff;
      type_in  = type_ff;
      seq_in   = seq_ff;
      ts_in    = ts_ff;
      kc_in    = kc_ff;
      vc_in    = vc_ff;
      mal_in   = mal_ff;
      hi_in    = hi_ff;
      ev_o     = '0;
      p34      = {2'b00, pos_ff};
      d34      = {2'b00, size_ff} - 34'd4;
      kb       = 34'd21 + {2'b00, kc_ff};
      off      = p34 - kb;
      pos_inc  = pos_ff + 32'd1;
      bsel     = pos_ff[2:0] - 3'd1;
      trunc    = 1'b0;
      if (take_i) begin
         unique case (phase_ff)
            PH_SIZE: begin
               size_in = {byte_i, size_ff[31:8]};
               pos_in  = pos_inc;
               if (pos_inc >= 32'd4) begin
                  if (size_in == 32'd0 || size_in > max_ff) begin
                     phase_in    = PH_STOP;
                     pos_in      = '0;
                     ev_o.a_vld  = 1'b1;
                     ev_o.a_kind = KIND_STOPPED;
                  end else begin
                     phase_in = PH_BODY;
                     pos_in   = '0;
                     crc_in   = CRC_INIT;
                     scs_in   = '0;
                     type_in  = '0;
                     seq_in   = '0;
                     ts_in    = '0;
                     kc_in    = '0;
                     vc_in    = '0;
                     mal_in   = size_in < 32'd29;
                  end
               end
            end
            PH_BODY: begin
               if (size_ff >= 32'd4) begin
                  if (p34 < d34) begin
                     crc_in = (crc_ff >> 8) ^ crc_entry(crc_ff[7:0] ^ byte_i);
                     if (!mal_ff) begin
                        if (pos_ff == 32'd0) begin
                           type_in = byte_i;
                        end else if (pos_ff <= 32'd8) begin
                           seq_in[{bsel, 3'b000} +: 8] = byte_i;
                        end else if (pos_ff <= 32'd16) begin
                           ts_in[{bsel, 3'b000} +: 8] = byte_i;
                        end else if (pos_ff <= 32'd20) begin
                           kc_in[{bsel[1:0], 3'b000} +: 8] = byte_i;
                           if (pos_ff == 32'd20 && HDR_BYTES + {2'b00, kc_in} > d34)
                              mal_in = 1'b1;
                        end else if (p34 < kb) begin
                           ev_o.a_vld  = 1'b1;
                           ev_o.a_kind = KIND_KEY;
                           ev_o.a_pay  = byte_i;
                        end else if (p34 < kb + 34'd4) begin
                           vc_in[{off[1:0], 3'b000} +: 8] = byte_i;
                           if (p34 == kb + 34'd3 &&
                               HDR_BYTES + {2'b00, kc_ff} + {2'b00, vc_in} > d34)
                              mal_in = 1'b1;
                        end else if (p34 < kb + 34'd4 + {2'b00, vc_ff}) begin
                           ev_o.a_vld  = 1'b1;
                           ev_o.a_kind = KIND_VALUE;
                           ev_o.a_pay  = byte_i;
                        end
                     end
                  end else begin
                     scs_in = {byte_i, scs_ff[31:8]};
                  end
               end
               pos_in = pos_inc;
               if (pos_inc == size_ff) begin
                  ev_o.a_vld = 1'b1;
                  if (size_ff < 32'd4 || (crc_in ^ CRC_INIT) != scs_in) begin
                     ev_o.a_kind = KIND_CRC_BAD;
                  end else if (mal_in) begin
                     ev_o.a_kind = KIND_MALFORMED;
                  end else begin
                     if (seq_in > hi_ff) hi_in = seq_in;
                     ev_o.a_kind = KIND_ACCEPTED;
                  end
                  phase_in = PH_SIZE;
                  size_in  = '0;
                  pos_in   = '0;
               end
            end
            default: ;
         endcase
         if (final_i) begin
            trunc       = (phase_in == PH_BODY) || (phase_in == PH_SIZE && pos_in != 32'd0);
            ev_o.b_vld  = 1'b1;
            ev_o.b_kind = trunc ? KIND_STOPPED : KIND_LOG_END;
            phase_in    = PH_SIZE;
            size_in     = '0;
            pos_in      = '0;
         end
      end
      ev_o.rec_type = type_in;
      ev_o.rec_seq  = seq_in;
      ev_o.rec_ts   = ts_in;
      ev_o.rec_klen = kc_in;
      ev_o.rec_vlen = vc_in;
      ev_o.highest  = hi_in;
      ev_vld_o      = ev_o.a_vld || ev_o.b_vld;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= MAX_FRAME_RESET;
         phase_ff <= PH_SIZE;
         size_ff  <= '0;
         pos_ff   <= '0;
         crc_ff   <= CRC_INIT;
         scs_ff   <= '0;
         type_ff  <= '0;
         seq_ff   <= '0;
         ts_ff    <= '0;
         kc_ff    <= '0;
         vc_ff    <= '0;
         mal_ff   <= 1'b0;
         hi_ff    <= '0;
      end else begin
         max_ff   <= max_in;
         phase_ff <= phase_in;
         size_ff  <= size_in;
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         scs_ff   <= scs_in;
         type_ff  <= type_in;
         seq_ff   <= seq_in;
         ts_ff    <= ts_in;
         kc_ff    <= kc_in;
         vc_ff    <= vc_in;
         mal_ff   <= mal_in;
         hi_ff    <= hi_in;
      end
   end

endmodule

// ----- rtl/core/lrd_queue.sv -----
// Event queue between front and back end, a small register FIFO.
// Depends on lrd_pkg and the assertion macro header.
`include "log_recovery_deframer_macros.svh"
module lrd_queue #(
   parameter int unsigned DEPTH = lrd_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_i,
   input  lrd_pkg::lrd_event_type push_data_i,
   input  logic                   pop_i,
   output logic                   full_o,
   output logic                   empty_o,
   output lrd_pkg::lrd_event_type head_o
);
   import lrd_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   lrd_event_type   mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] ptr);
      return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
   endfunction

   assign full_o  = count_ff == CW'(DEPTH);
   assign empty_o = count_ff == '0;
   assign head_o  = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push_i ? bump(wr_ff) : wr_ff;
      rd_in    = pop_i ? bump(rd_ff) : rd_ff;
      count_in = count_ff + CW'(push_i) - CW'(pop_i);
   end

   always_ff @(posedge clock) begin
      if (push_i) mem_ff[wr_ff] <= push_data_i;
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   `LRD_ASSERT_NOW(a_no_overflow, clock, reset, push_i, !full_o)
   `LRD_ASSERT_NOW(a_no_underflow, clock, reset, pop_i, !empty_o)
   `LRD_ASSERT_NEXT(a_count_up, clock, reset, push_i && !pop_i, count_ff == $past(count_ff) + CW'(1))

endmodule

// ----- rtl/core/lrd_back.sv -----
// Back end: expands queued events into one or two results and holds them
// in the output register. Depends on lrd_pkg and lrd_rsp_if.
module lrd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   empty_i,
   input  lrd_pkg::lrd_event_type head_i,
   output logic                   pop_o,
   lrd_rsp_if.source              rsp_bus
);
   import lrd_pkg::*;

   logic        part_ff, part_in;
   logic        vld_ff, vld_in;
   logic [2:0]  kind_ff, kind_in;
   logic [7:0]  pay_ff, pay_in;
   logic [7:0]  type_ff, type_in;
   logic [63:0] seq_ff, seq_in;
   logic [63:0] ts_ff, ts_in;
   logic [31:0] klen_ff, klen_in;
   logic [31:0] vlen_ff, vlen_in;
   logic [63:0] hi_ff, hi_in;
   logic        last_ff, last_in;
   logic        issue, use_a, rec;

   always_comb begin
      issue   = !empty_i && (!vld_ff || rsp_bus.ready);
      use_a   = !part_ff && head_i.a_vld;
      vld_in  = issue ? 1'b1 : (vld_ff && !rsp_bus.ready);
      kind_in = kind_ff;
      pay_in  = pay_ff;
      type_in = type_ff;
      seq_in  = seq_ff;
      ts_in   = ts_ff;
      klen_in = klen_ff;
      vlen_in = vlen_ff;
      hi_in   = hi_ff;
      last_in = last_ff;
      part_in = part_ff;
      pop_o   = 1'b0;
      rec     = 1'b0;
      if (issue) begin
         kind_in = use_a ? head_i.a_kind : head_i.b_kind;
         pay_in  = use_a ? head_i.a_pay : 8'd0;
         last_in = use_a ? !head_i.b_vld : 1'b1;
         rec     = kind_in == KIND_ACCEPTED;
         type_in = rec ? head_i.rec_type : '0;
         seq_in  = rec ? head_i.rec_seq : '0;
         ts_in   = rec ? head_i.rec_ts : '0;
         klen_in = rec ? head_i.rec_klen : '0;
         vlen_in = rec ? head_i.rec_vlen : '0;
         hi_in   = head_i.highest;
         pop_o   = last_in;
         part_in = !last_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      pay_ff  <= pay_in;
      type_ff <= type_in;
      seq_ff  <= seq_in;
      ts_ff   <= ts_in;
      klen_ff <= klen_in;
      vlen_ff <= vlen_in;
      hi_ff   <= hi_in;
      last_ff <= last_in;
      if (reset) begin
         vld_ff  <= 1'b0;
         part_ff <= 1'b0;
      end else begin
         vld_ff  <= vld_in;
         part_ff <= part_in;
      end
   end

   assign rsp_bus.valid            = vld_ff;
   assign rsp_bus.kind             = kind_ff;
   assign rsp_bus.payload_byte     = pay_ff;
   assign rsp_bus.record_type      = type_ff;
   assign rsp_bus.sequence_number  = seq_ff;
   assign rsp_bus.time_stamp       = ts_ff;
   assign rsp_bus.key_length       = klen_ff;
   assign rsp_bus.value_length     = vlen_ff;
   assign rsp_bus.highest_sequence = hi_ff;
   assign rsp_bus.last             = last_ff;

endmodule

// ----- tb/testbench.sv -----
// Testbench for log_recovery_deframer: drives log bytes, predicts every result and checks it.
// Depends on lrd_pkg, lrd_req_if, lrd_rsp_if and the log_recovery_deframer top level.
module testbench;
   import lrd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // one result record as the block presents it
   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  pay;
      logic [7:0]  rtype;
      logic [63:0] seq;
      logic [63:0] ts;
      logic [31:0] klen;
      logic [31:0] vlen;
      logic [63:0] high;
      logic        last;
   } deframe_result_type;

   typedef struct packed {
      logic [7:0] b;
      logic       fin;
   } log_byte_type;

   // directed row: byte, end-of-log mark, and the kind of the last result where obvious
   typedef struct packed {
      logic [7:0] b;
      logic       fin;
      logic       typed;
      logic [2:0] kind;
   } dir_row_type;

   localparam int DIR_ROWS = 23;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_BYTES = 300;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [31:0] csr_wdata;

   lrd_req_if req_bus();
   lrd_rsp_if rsp_bus();

   log_recovery_deframer u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus.sink),
      .rsp_bus   (rsp_bus.source)
   );

   // ------------------------------------------------------------------
   // Parser shadow state, updated once per accepted log byte
   // ------------------------------------------------------------------
   logic [31:0] frame_limit = MAX_FRAME_RESET;
   logic [1:0]  parse_phase = PH_SIZE;
   logic [31:0] frame_len = '0;
   logic [31:0] body_pos = '0;
   logic [31:0] body_crc = CRC_INIT;
   logic [31:0] trailer_crc = '0;
   logic [7:0]  rec_type = '0;
   logic [63:0] rec_seq = '0;
   logic [63:0] rec_ts = '0;
   logic [31:0] rec_klen = '0;
   logic [31:0] rec_vlen = '0;
   logic        rec_bad = 1'b0;
   logic [63:0] seq_high = '0;

   deframe_result_type pending_results[$];
   int unsigned        fail_count = 0;
   int unsigned        quiet_cycles = 0;
   log_byte_type       log_q[$];

   function automatic logic [31:0] crc_advance(input logic [31:0] c, input logic [7:0] b);
      c = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic deframe_result_type make_result(input logic [2:0] kind,
                                                      input logic [7:0] pay,
                                                      input logic rec);
      deframe_result_type r;
      r = '0;
      r.kind = kind;
      r.pay = pay;
      if (rec) begin
         r.rtype = rec_type;
         r.seq = rec_seq;
         r.ts = rec_ts;
         r.klen = rec_klen;
         r.vlen = rec_vlen;
      end
      r.high = seq_high;
      return r;
   endfunction

   // Advance the shadow parser by one byte and queue the results it causes.
   task automatic predict_byte(input logic [7:0] b, input logic fin);
      deframe_result_type outs[$];
      logic               trunc;
      logic [63:0]        p;
      logic [63:0]        d;
      logic [63:0]        kb;
      if (parse_phase == PH_SIZE) begin
         frame_len = {b, frame_len[31:8]};
         body_pos++;
         if (body_pos >= 4) begin
            if (frame_len == 0 || frame_len > frame_limit) begin
               parse_phase = PH_STOP;
               body_pos = 0;
               outs.insert(outs.size(), make_result(KIND_STOPPED, 8'd0, 1'b0));
            end else begin
               // open the body; records under the fixed header length are malformed up front
               parse_phase = PH_BODY;
               body_pos = 0;
               body_crc = CRC_INIT;
               trailer_crc = '0;
               rec_type = '0;
               rec_seq = '0;
               rec_ts = '0;
               rec_klen = '0;
               rec_vlen = '0;
               rec_bad = (frame_len < HDR_BYTES + 4);
            end
         end
      end else if (parse_phase == PH_BODY) begin
         p = 64'(body_pos);
         if (frame_len >= 4) begin
            d = 64'(frame_len) - 64'd4;
            if (p < d) begin
               body_crc = crc_advance(body_crc, b);
               if (!rec_bad) begin
                  kb = 64'd21 + 64'(rec_klen);
                  if (p == 0) begin
                     rec_type = b;
                  end else if (p <= 8) begin
                     rec_seq[8*(p-1) +: 8] = b;
                  end else if (p <= 16) begin
                     rec_ts[8*(p-9) +: 8] = b;
                  end else if (p <= 20) begin
                     rec_klen[8*(p-17) +: 8] = b;
                     if (p == 20 && 64'(HDR_BYTES) + 64'(rec_klen) > d) rec_bad = 1'b1;
                  end else if (p < kb) begin
                     outs.insert(outs.size(), make_result(KIND_KEY, b, 1'b0));
                  end else if (p < kb + 4) begin
                     rec_vlen[8*(p-kb) +: 8] = b;
                     if (p == kb + 3 &&
                         64'(HDR_BYTES) + 64'(rec_klen) + 64'(rec_vlen) > d) rec_bad = 1'b1;
                  end else if (p < kb + 4 + 64'(rec_vlen)) begin
                     outs.insert(outs.size(), make_result(KIND_VALUE, b, 1'b0));
                  end
               end
            end else begin
               trailer_crc = {b, trailer_crc[31:8]};
            end
         end
         body_pos++;
         if (body_pos == frame_len) begin
            // CRC is judged before the malformed flag
            if (frame_len < 4 || (body_crc ^ CRC_INIT) != trailer_crc) begin
               outs.insert(outs.size(), make_result(KIND_CRC_BAD, 8'd0, 1'b0));
            end else if (rec_bad) begin
               outs.insert(outs.size(), make_result(KIND_MALFORMED, 8'd0, 1'b0));
            end else begin
               if (rec_seq > seq_high) seq_high = rec_seq;
               outs.insert(outs.size(), make_result(KIND_ACCEPTED, 8'd0, 1'b1));
            end
            parse_phase = PH_SIZE;
            frame_len = '0;
            body_pos = '0;
         end
      end
      if (fin) begin
         // a partly read size field or body at log end counts as truncation
         trunc = (parse_phase == PH_BODY) || (parse_phase == PH_SIZE && body_pos != 0);
         outs.insert(outs.size(),
                     make_result(trunc ? KIND_STOPPED : KIND_LOG_END, 8'd0, 1'b0));
         parse_phase = PH_SIZE;
         frame_len = '0;
         body_pos = '0;
      end
      if (outs.size() > 0) outs[$].last = 1'b1;
      foreach (outs[i]) pending_results.insert(pending_results.size(), outs[i]);
   endtask

   // ------------------------------------------------------------------
   // Log generation: frames with random content, most of them well formed
   // ------------------------------------------------------------------
   task automatic push_le32(input logic [31:0] v, input logic fin_last);
      for (int i = 0; i < 4; i++)
         log_q.insert(log_q.size(), log_byte_type'{v[8*i +: 8], fin_last && i == 3});
   endtask

   task automatic build_frame();
      logic [7:0]  rec[$];
      logic [63:0] seq;
      logic [31:0] klen;
      logic [31:0] vlen;
      logic [31:0] crc;
      logic [31:0] flen;
      int          pick;
      int          nkey;
      int          nval;
      int          cut;
      pick = $urandom_range(0, 99);
      if (pick >= 86 && pick < 92) begin
         // bad size: zero or over the limit, then junk that the block drops
         flen = ($urandom_range(0, 1) || frame_limit == 32'hFFFF_FFFF) ? 32'd0
                : frame_limit + 32'($urandom_range(1, 100));
         if (flen < frame_limit && flen != 0) flen = 32'd0;
         push_le32(flen, 1'b0);
         repeat ($urandom_range(0, 3))
            log_q.insert(log_q.size(), log_byte_type'{8'($urandom()), 1'b0});
         log_q.insert(log_q.size(), log_byte_type'{8'($urandom()), 1'b1});
         return;
      end
      if (pick >= 80 && pick < 86) begin
         // record too short for its header, or a frame too short for a CRC
         nkey = $urandom_range(0, 24);
         for (int i = 0; i < nkey; i++) rec.insert(rec.size(), 8'($urandom()));
      end else begin
         case ($urandom_range(0, 2))
            0: seq = '0;
            1: seq = '1;
            default: seq = {$urandom(), $urandom()};
         endcase
         nkey = $urandom_range(0, 4);
         nval = $urandom_range(0, 4);
         klen = 32'(nkey);
         vlen = 32'(nval);
         if (pick >= 70 && pick < 75) klen = $urandom_range(0, 1) ? 32'hFFFF_FFFF
                                                                   : klen + 32'd40;
         if (pick >= 75 && pick < 80) vlen = $urandom_range(0, 1) ? $urandom() : vlen + 32'd9;
         rec.insert(rec.size(), 8'($urandom()));
         for (int i = 0; i < 8; i++) rec.insert(rec.size(), seq[8*i +: 8]);
         for (int i = 0; i < 8; i++) rec.insert(rec.size(), 8'($urandom()));
         for (int i = 0; i < 4; i++) rec.insert(rec.size(), klen[8*i +: 8]);
         for (int i = 0; i < nkey; i++) rec.insert(rec.size(), 8'($urandom()));
         for (int i = 0; i < 4; i++) rec.insert(rec.size(), vlen[8*i +: 8]);
         for (int i = 0; i < nval; i++) rec.insert(rec.size(), 8'($urandom()));
         repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 2) : 0)
            rec.insert(rec.size(), 8'($urandom()));
      end
      crc = CRC_INIT;
      foreach (rec[i]) crc = crc_advance(crc, rec[i]);
      crc = crc ^ CRC_INIT;
      if (pick >= 60 && pick < 70) crc[$urandom_range(0, 31)] ^= 1'b1;
      flen = 32'(rec.size() + 4);
      if (pick >= 80 && pick < 86 && $urandom_range(0, 3) == 0) begin
         // body of one to three bytes only
         flen = $urandom_range(1, 3);
         push_le32(flen, 1'b0);
         for (int i = 0; i < flen; i++)
            log_q.insert(log_q.size(), log_byte_type'{8'($urandom()), 1'b0});
         return;
      end
      push_le32(flen, 1'b0);
      foreach (rec[i]) log_q.insert(log_q.size(), log_byte_type'{rec[i], 1'b0});
      push_le32(crc, 1'b0);
      if (pick >= 92) begin
         // truncate: end the log somewhere inside the frame
         cut = $urandom_range(1, int'(flen) + 3);
         while (cut-- > 0) void'(log_q.pop_back());
         log_q[$].fin = 1'b1;
      end
   endtask

   // ------------------------------------------------------------------
   // Clock, sender and receiver
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   logic send_burst = 1'b0;

   // Present one byte after a random gap, hold until transfer, then predict.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      if ($urandom_range(0, 31) == 0) send_burst = ~send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.log_byte <= b;
      req_bus.final_req <= fin;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_byte(b, fin);
   endtask

   // Drain the block, then rewrite the frame limit.
   task automatic set_frame_limit(input logic [31:0] v);
      req_bus.valid <= 1'b0;
      while (pending_results.size() > 0) @(posedge clock);
      repeat (12) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      frame_limit = v;
   endtask

   int unsigned stall_left = 0;
   logic        recv_burst = 1'b0;

   // Receiver: after each result transfer, hold ready low for a random stall.
   always @(posedge clock) begin
      int unsigned nxt;
      nxt = stall_left;
      if (rsp_bus.valid && rsp_bus.ready) begin
         if ($urandom_range(0, 31) == 0) recv_burst = ~recv_burst;
         nxt = recv_burst ? 0 : $urandom_range(0, 8);
      end else if (nxt > 0) begin
         nxt--;
      end
      stall_left = nxt;
      rsp_bus.ready <= reset ? 1'b0 : (nxt == 0);
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Compare each result transfer with the oldest prediction.
   always @(posedge clock) begin
      deframe_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result: kind %0d", $time, rsp_bus.kind);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("kind", 64'(want.kind), 64'(rsp_bus.kind));
            check_field("payload_byte", 64'(want.pay), 64'(rsp_bus.payload_byte));
            check_field("record_type", 64'(want.rtype), 64'(rsp_bus.record_type));
            check_field("sequence_number", want.seq, rsp_bus.sequence_number);
            check_field("time_stamp", want.ts, rsp_bus.time_stamp);
            check_field("key_length", 64'(want.klen), 64'(rsp_bus.key_length));
            check_field("value_length", 64'(want.vlen), 64'(rsp_bus.value_length));
            check_field("highest_sequence", want.high, rsp_bus.highest_sequence);
            check_field("last", 64'(want.last), 64'(rsp_bus.last));
         end
      end
   end

   // Watchdog: stop when transfers dry up while work is outstanding.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (pending_results.size() == 0 && !req_bus.valid)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("[log_recovery_deframer] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   dir_row_type dir_rows [0:DIR_ROWS-1] = '{
      // zero size stops the parser; bytes are dropped until log end
      '{8'h00, 1'b0, 1'b0, KIND_KEY}, '{8'h00, 1'b0, 1'b0, KIND_KEY},
      '{8'h00, 1'b0, 1'b0, KIND_KEY}, '{8'h00, 1'b0, 1'b1, KIND_STOPPED},
      '{8'hFF, 1'b0, 1'b0, KIND_KEY}, '{8'h00, 1'b1, 1'b1, KIND_LOG_END},
      // two-byte frame: too short to carry a CRC
      '{8'h02, 1'b0, 1'b0, KIND_KEY}, '{8'h00, 1'b0, 1'b0, KIND_KEY},
      '{8'h00, 1'b0, 1'b0, KIND_KEY}, '{8'h00, 1'b0, 1'b0, KIND_KEY},
      '{8'hAB, 1'b0, 1'b0, KIND_KEY}, '{8'hCD, 1'b0, 1'b1, KIND_CRC_BAD},
      // all-ones size is over the reset limit
      '{8'hFF, 1'b0, 1'b0, KIND_KEY}, '{8'hFF, 1'b0, 1'b0, KIND_KEY},
      '{8'hFF, 1'b0, 1'b0, KIND_KEY}, '{8'hFF, 1'b0, 1'b1, KIND_STOPPED},
      '{8'h5A, 1'b1, 1'b1, KIND_LOG_END},
      // log ends inside a size field
      '{8'h80, 1'b1, 1'b1, KIND_STOPPED},
      // one-byte frame whose only byte ends the log: verdict, then log end
      '{8'h01, 1'b0, 1'b0, KIND_KEY}, '{8'h00, 1'b0, 1'b0, KIND_KEY},
      '{8'h00, 1'b0, 1'b0, KIND_KEY}, '{8'h00, 1'b0, 1'b0, KIND_KEY},
      '{8'h7F, 1'b1, 1'b1, KIND_LOG_END}
   };

   logic [31:0] limit_plan [0:4];

   initial begin
      limit_plan = '{32'hFFFF_FFFF, 32'd1, 32'd40, 32'd29, MAX_FRAME_RESET};
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.log_byte = '0;
      req_bus.final_req = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         send_byte(dir_rows[i].b, dir_rows[i].fin);
         if (dir_rows[i].typed &&
             (pending_results.size() == 0 || pending_results[$].kind != dir_rows[i].kind)) begin
            $display("%0t directed row %0d: expected kind %0d", $time, i, dir_rows[i].kind);
            fail_count++;
         end
      end

      // random logs, one per frame limit setting, each closed by a log end
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) set_frame_limit(limit_plan[ph-1]);
         while (log_q.size() < PHASE_BYTES) build_frame();
         log_q[$].fin = 1'b1;
         while (log_q.size() > 0) begin
            log_byte_type lb;
            lb = log_q.pop_front();
            send_byte(lb.b, lb.fin);
         end
      end
      req_bus.valid <= 1'b0;

      while (pending_results.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("[log_recovery_deframer] OK");
      end else begin
         $display("[log_recovery_deframer] ERROR");
      end
      $finish;
   end

endmodule
